@@ src/tsu_pkg.sv @@
package tsu_pkg;

  localparam int RawW     = 48;
  localparam int StampW   = 64;
  localparam int BitsW    = 6;
  localparam int SpanW    = RawW + 1;
  localparam int LoW      = RawW - 1;
  localparam int GapW     = 63;
  localparam int StepW    = 48;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  localparam int MinBits  = 8;
  localparam int MaxBits  = 48;

  localparam logic [BitsW-1:0]        TsBitsRst = BitsW'(32);
  localparam logic [GapW-1:0]         GapThrRst = GapW'(90000);
  localparam logic signed [StepW-1:0] FixStepRst = StepW'(3000);

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TS_BITS       = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_GAP_THRESHOLD = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_GAP_FIX_STEP  = cfg_idx_t'(2);

  typedef struct packed {
    logic [BitsW-1:0] eff_bits;
    logic [SpanW-1:0] span;
    logic [RawW-1:0]  mask;
    logic [LoW-1:0]   lo_edge;
    logic [RawW-1:0]  hi_edge;
  } tsu_width_t;

  typedef struct packed {
    tsu_width_t               w;
    logic [GapW-1:0]          gap_thr;
    logic signed [StepW-1:0]  fix_step;
  } tsu_cfg_t;

  function automatic tsu_width_t tsu_width(input logic [BitsW-1:0] bits);
    tsu_width_t       w;
    logic [BitsW-1:0] e;
    if (bits < BitsW'(MinBits)) begin
      e = BitsW'(MinBits);
    end else if (bits > BitsW'(MaxBits)) begin
      e = BitsW'(MaxBits);
    end else begin
      e = bits;
    end
    w.eff_bits = e;
    w.span     = SpanW'(1) << e;
    w.mask     = w.span[RawW-1:0] - RawW'(1);
    w.lo_edge  = LoW'(1) << (e - BitsW'(2));
    w.hi_edge  = RawW'(w.span - SpanW'(w.lo_edge));
    return w;
  endfunction

endpackage

@@ src/tsu_if.sv @@
interface tsu_in_if;
  import tsu_pkg::*;

  logic            valid;
  logic            ready;
  logic            req_type;
  logic [RawW-1:0] raw_stamp;

  modport source(output valid, req_type, raw_stamp, input ready);
  modport sink(input valid, req_type, raw_stamp, output ready);
endinterface

interface tsu_out_if;
  import tsu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [StampW-1:0] norm_stamp;
  logic                     gap_fixed;

  modport source(output valid, norm_stamp, gap_fixed, input ready);
  modport sink(input valid, norm_stamp, gap_fixed, output ready);
endinterface

interface tsu_cfg_if;
  import tsu_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/timestamp_unwrap_gap_fix.sv @@
// A sample beat passes the input register and then the result register on its way to the
// result channel; a stall on the result channel holds it back.
// Throughput: one input beat per cycle unless the result channel stalls; the wrap tracker,
// unwrap sum and gap check share one combinational pass between the input register and the result register.
// A restart beat updates the tracker and produces no result beat.
// Synchronous active-low reset clears the tracker and restores the register defaults.
module timestamp_unwrap_gap_fix (
  input logic        clk,
  input logic        rst_n,
  tsu_in_if.sink     in_ch,
  tsu_out_if.source  out_ch,
  tsu_cfg_if.sink    cfg_ch
);
  import tsu_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_WRAPPED
  } phase_t;

  tsu_cfg_t cfg;

  tsu_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_o (cfg)
  );

  logic              s1_valid_r;
  logic              s1_restart_r;
  logic [RawW-1:0]   s1_raw_r;

  logic              out_valid_r;
  logic [StampW-1:0] out_stamp_r;
  logic              out_fixed_r;

  logic              origin_valid_r;
  logic [StampW-1:0] origin_r;
  phase_t            phase_r;
  logic [StampW-1:0] count_r;
  logic              prev_valid_r;
  logic [StampW-1:0] prev_out_r;

  logic              out_free;
  logic              s1_adv;
  logic              in_acc;

  logic [RawW-1:0]   ts;
  logic [StampW-1:0] org;
  logic              above_hi;
  logic              at_low;
  phase_t            phase_mid;
  logic [StampW-1:0] count_mid;
  logic [SpanW-1:0]  ts_adj;
  logic [StampW-1:0] raw_nts;
  logic [StampW-1:0] diff;
  logic [StampW-1:0] mag;
  logic              gap;
  logic [StampW-1:0] fix_nts;

  logic [StampW-1:0] nts_nxt;
  logic [StampW-1:0] origin_nxt;
  phase_t            phase_nxt;
  logic [StampW-1:0] count_nxt;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.norm_stamp = out_stamp_r;
  assign out_ch.gap_fixed  = out_fixed_r;

  always_comb begin
    ts       = s1_raw_r & cfg.w.mask;
    org      = origin_valid_r ? origin_r : StampW'(ts);
    above_hi = ts > cfg.w.hi_edge;
    at_low   = ts <= RawW'(cfg.w.lo_edge);

    phase_mid = phase_r;
    count_mid = count_r;
    if (above_hi && phase_r == PH_IDLE) begin
      phase_mid = PH_HIGH;
    end else if (at_low && phase_r == PH_HIGH) begin
      phase_mid = PH_WRAPPED;
    end else if (!at_low && !above_hi && phase_r == PH_WRAPPED) begin
      phase_mid = PH_IDLE;
      count_mid = count_r + StampW'(1);
    end

    ts_adj  = (phase_mid != PH_IDLE && at_low) ? (SpanW'(ts) | cfg.w.span) : SpanW'(ts);
    raw_nts = StampW'(ts_adj) + (count_mid << cfg.w.eff_bits) - org;

    diff    = raw_nts - prev_out_r;
    mag     = diff[StampW-1] ? (StampW'(0) - diff) : diff;
    gap     = prev_valid_r && (mag > StampW'(cfg.gap_thr));
    fix_nts = prev_out_r + StampW'(signed'(cfg.fix_step));

    if (gap) begin
      nts_nxt    = fix_nts;
      origin_nxt = StampW'(ts_adj) - fix_nts;
      phase_nxt  = (ts_adj > SpanW'(cfg.w.hi_edge)) ? PH_HIGH : PH_IDLE;
      count_nxt  = '0;
    end else begin
      nts_nxt    = raw_nts;
      origin_nxt = org;
      phase_nxt  = phase_mid;
      count_nxt  = count_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_restart_r <= in_ch.req_type;
      s1_raw_r     <= in_ch.raw_stamp;
    end
    if (s1_adv && !s1_restart_r) begin
      out_stamp_r <= nts_nxt;
      out_fixed_r <= gap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      origin_valid_r <= 1'b0;
      origin_r       <= '0;
      phase_r        <= PH_IDLE;
      count_r        <= '0;
      prev_valid_r   <= 1'b0;
      prev_out_r     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv && !s1_restart_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        if (s1_restart_r) begin
          origin_valid_r <= 1'b0;
          origin_r       <= '0;
          phase_r        <= PH_IDLE;
          count_r        <= '0;
        end else begin
          origin_valid_r <= 1'b1;
          origin_r       <= origin_nxt;
          phase_r        <= phase_nxt;
          count_r        <= count_nxt;
          prev_valid_r   <= 1'b1;
          prev_out_r     <= nts_nxt;
        end
      end
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stage empty but not ready");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_restart_r |=> !origin_valid_r && count_r == '0 && phase_r == PH_IDLE)
    else $error("restart did not clear the tracker");

  a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_restart_r |=>
      out_valid_r && prev_valid_r && origin_valid_r && out_stamp_r == prev_out_r)
    else $error("sample did not produce a matching result");

  a_no_fix_first: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_restart_r && !prev_valid_r |=> !out_fixed_r)
    else $error("gap repair applied without a previous output");

endmodule

@@ src/tsu_cfg_regs.sv @@
module tsu_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  tsu_cfg_if.sink          cfg,
  output tsu_pkg::tsu_cfg_t cfg_o
);
  import tsu_pkg::*;

  tsu_cfg_t cfg_r;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.w        <= tsu_width(TsBitsRst);
      cfg_r.gap_thr  <= GapThrRst;
      cfg_r.fix_step <= FixStepRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TS_BITS:       cfg_r.w        <= tsu_width(cfg.data[BitsW-1:0]);
        CFG_GAP_THRESHOLD: cfg_r.gap_thr  <= cfg.data[GapW-1:0];
        CFG_GAP_FIX_STEP:  cfg_r.fix_step <= cfg.data[StepW-1:0];
        default: ;
      endcase
    end
  end

endmodule
